>>> src/pfa_pkg.sv
// Shared constants, codes and types of the page frame allocator.
`default_nettype none

package pfa_pkg;

    // Default geometry
    localparam int PFA_MAX_PAGE_FRAMES = 4096;
    localparam int PFA_RESERVED_PAGES  = 256;
    localparam int PFA_PAGE_BYTES      = 4096;

    // Fixed field widths
    localparam int WORD_W       = 64;   // bits of the used map per memory word
    localparam int IDX_W        = 6;    // bit index within one word
    localparam int PA_W         = 24;   // physical page address on the result
    localparam int LIMIT_W      = 13;   // page_limit register
    localparam int DATA_W       = 64;   // address field and config data
    localparam int PAGE_BYTES_W = 17;   // holds any page size up to 65536
    localparam int CFG_IDX_W    = 1;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_XLAT,
        ST_FREE_WR,
        ST_RESP
    } pfa_state_t;

    typedef enum logic [1:0] {
        XP_IDLE,
        XP_RANGE
    } xlat_phase_t;

    typedef struct packed {
        logic done;
        logic in_range;
    } xlat_status_t;

endpackage

`default_nettype wire

>>> src/page_frame_allocator_core.sv
// Top level of the first-fit page frame allocator.
`default_nettype none

// First-fit page frame allocator. The used map (one bit per frame) lives in a
// memory of 64-bit words with registered reads. After reset the block sweeps
// the memory once, one word per cycle, marking the RESERVED_PAGES lowest
// frames used; s_ready stays low during that sweep while configuration writes
// are taken as usual. An allocate item (s_command = 0) streams words starting
// at the word that holds frame RESERVED_PAGES, one read per cycle, up to the
// word that holds frame min(page_limit, MAX_PAGE_FRAMES) - 1; the first word
// with a free frame in the window is written back with that bit set in the
// cycle it is examined. Allocation reads at most 60 words with the default
// geometry and is bound by the single memory read port. A failed allocation
// returns address 0 with m_ok low. A free item subtracts virt_base when the
// address lies strictly above it, checks the result against the map size and
// takes the frame number from the address bits above the page offset
// (PAGE_BYTES must be a power of two), then reads, clears and writes back the
// frame's bit. Out of range frees leave the map untouched and return m_ok low.
// One item is in work at a time; the result register lets the next item in
// while a result waits for m_ready. The user must write configuration only
// while no item is in work; the block itself does not enforce it.
module page_frame_allocator_core #(
    parameter int MAX_PAGE_FRAMES = pfa_pkg::PFA_MAX_PAGE_FRAMES,
    parameter int RESERVED_PAGES  = pfa_pkg::PFA_RESERVED_PAGES,
    parameter int PAGE_BYTES      = pfa_pkg::PFA_PAGE_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [pfa_pkg::DATA_W-1:0]    s_address,
    // result items
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pfa_pkg::PA_W-1:0]      m_page_address,
    output logic                               m_ok,
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pfa_pkg::DATA_W-1:0]    cfg_wdata
);
    import pfa_pkg::*;

    localparam int NUM_WORDS = (MAX_PAGE_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PTR_W     = WADDR_W + 1;
    localparam int FRAME_W   = WADDR_W + IDX_W;
    localparam int CMP_W     = (FRAME_W + 1 > LIMIT_W) ? FRAME_W + 1 : LIMIT_W;
    localparam int PROD_W    = (FRAME_W + PAGE_BYTES_W > PA_W) ? FRAME_W + PAGE_BYTES_W : PA_W;
    localparam int RES_FULL  = RESERVED_PAGES / WORD_W;

    localparam logic [WADDR_W-1:0] START_WADDR = WADDR_W'(RESERVED_PAGES / WORD_W);
    localparam logic [WADDR_W-1:0] LAST_INIT   = WADDR_W'(NUM_WORDS - 1);
    localparam logic [IDX_W-1:0]   RES_BIT     = IDX_W'(RESERVED_PAGES % WORD_W);
    localparam logic [CMP_W-1:0]   MAX_TOP     = CMP_W'(MAX_PAGE_FRAMES);
    localparam logic [CMP_W-1:0]   RES_TOP     = CMP_W'(RESERVED_PAGES);
    localparam logic [WORD_W-1:0]  ALL_ONES    = {WORD_W{1'b1}};

    // reset contents of one map word
    function automatic logic [WORD_W-1:0] init_word(input logic [WADDR_W-1:0] w);
        if (int'(w) < RES_FULL) begin
            return ALL_ONES;
        end else if (int'(w) == RES_FULL) begin
            return (WORD_W'(1) << RES_BIT) - WORD_W'(1);
        end else begin
            return '0;
        end
    endfunction

    // control state
    pfa_state_t          state_reg, state_next;
    logic [WADDR_W-1:0]  init_ptr_reg, init_ptr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                m_valid_reg, m_valid_next;
    logic [LIMIT_W-1:0]  page_limit_reg;
    logic [DATA_W-1:0]   virt_base_reg;

    // work registers
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [WADDR_W-1:0]  chk_ptr_reg, chk_ptr_next;
    logic [WADDR_W-1:0]  last_word_reg, last_word_next;
    logic [IDX_W-1:0]    last_bit_reg, last_bit_next;
    logic [WADDR_W-1:0]  tgt_word_reg, tgt_word_next;
    logic [IDX_W-1:0]    tgt_bit_reg, tgt_bit_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic                ok_reg, ok_next;
    logic [PA_W-1:0]     m_page_address_reg, m_page_address_next;
    logic                m_ok_reg, m_ok_next;

    // memory port
    logic                mem_we;
    logic [WADDR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [WADDR_W-1:0]  mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;

    // scan datapath
    logic [CMP_W-1:0]    top_frames;
    logic [CMP_W-1:0]    top_m1;
    logic                alloc_empty;
    logic [WORD_W-1:0]   lo_mask;
    logic [WORD_W-1:0]   hi_mask;
    logic                ff_any;
    logic [IDX_W-1:0]    ff_idx;
    logic [WORD_W-1:0]   ff_lowest;
    logic                scan_hit;
    logic                scan_miss;
    logic                rd_more;

    // translation unit
    logic                xlat_start;
    xlat_status_t        xst;
    logic [FRAME_W-1:0]  xframe;

    logic                s_accept;
    logic                out_free;
    logic [PROD_W-1:0]   prod;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // scan window: frames RESERVED_PAGES .. min(page_limit, map size) - 1
    assign top_frames  = (CMP_W'(page_limit_reg) > MAX_TOP) ? MAX_TOP : CMP_W'(page_limit_reg);
    assign top_m1      = top_frames - CMP_W'(1);
    assign alloc_empty = (top_frames <= RES_TOP);

    assign lo_mask = (chk_ptr_reg == START_WADDR) ? (ALL_ONES << RES_BIT) : ALL_ONES;
    assign hi_mask = (chk_ptr_reg == last_word_reg) ? (ALL_ONES >> ~last_bit_reg) : ALL_ONES;

    assign scan_hit  = (state_reg == ST_SCAN) && chk_vld_reg && ff_any;
    assign scan_miss = (state_reg == ST_SCAN) && chk_vld_reg && !ff_any
                       && (chk_ptr_reg == last_word_reg);
    assign rd_more   = rd_ptr_reg <= {1'b0, last_word_reg};

    assign xlat_start = s_accept && (s_command == CMD_FREE);

    // frame to physical address; the output register follows
    assign prod = PROD_W'(frame_reg) * PROD_W'(PAGE_BYTES);

    pfa_map_mem #(
        .NUM_WORDS (NUM_WORDS),
        .WADDR_W   (WADDR_W)
    ) u_map_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfa_find_free u_find_free (
        .word   (mem_rdata),
        .mask   (lo_mask & hi_mask),
        .any    (ff_any),
        .idx    (ff_idx),
        .lowest (ff_lowest)
    );

    pfa_xlat #(
        .MAX_PAGE_FRAMES (MAX_PAGE_FRAMES),
        .PAGE_BYTES      (PAGE_BYTES),
        .FRAME_W         (FRAME_W)
    ) u_xlat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (xlat_start),
        .address   (s_address),
        .virt_base (virt_base_reg),
        .status    (xst),
        .frame     (xframe)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (init_ptr_reg == LAST_INIT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_command == CMD_FREE) begin
                        state_next = ST_XLAT;
                    end else if (alloc_empty) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_miss) begin
                    state_next = ST_RESP;
                end
            end
            ST_XLAT: begin
                if (xst.done) begin
                    state_next = xst.in_range ? ST_FREE_WR : ST_RESP;
                end
            end
            ST_FREE_WR: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // memory accesses and datapath updates
    always_comb begin
        mem_we              = 1'b0;
        mem_waddr           = chk_ptr_reg;
        mem_wdata           = mem_rdata | ff_lowest;
        mem_re              = 1'b0;
        mem_raddr           = rd_ptr_reg[WADDR_W-1:0];
        init_ptr_next       = init_ptr_reg;
        rd_ptr_next         = rd_ptr_reg;
        chk_ptr_next        = chk_ptr_reg;
        chk_vld_next        = chk_vld_reg;
        last_word_next      = last_word_reg;
        last_bit_next       = last_bit_reg;
        tgt_word_next       = tgt_word_reg;
        tgt_bit_next        = tgt_bit_reg;
        frame_next          = frame_reg;
        ok_next             = ok_reg;
        // drop the result once taken
        m_valid_next        = m_valid_reg && !m_ready;
        m_page_address_next = m_page_address_reg;
        m_ok_next           = m_ok_reg;

        unique case (state_reg)
            ST_INIT: begin
                mem_we        = 1'b1;
                mem_waddr     = init_ptr_reg;
                mem_wdata     = init_word(init_ptr_reg);
                init_ptr_next = init_ptr_reg + WADDR_W'(1);
            end
            ST_IDLE: begin
                if (s_accept) begin
                    frame_next     = '0;
                    ok_next        = 1'b0;
                    rd_ptr_next    = {1'b0, START_WADDR};
                    chk_vld_next   = 1'b0;
                    last_word_next = top_m1[FRAME_W-1:IDX_W];
                    last_bit_next  = top_m1[IDX_W-1:0];
                end
            end
            ST_SCAN: begin
                // stream one word read per cycle, examine the previous one
                mem_re       = rd_more;
                chk_vld_next = rd_more;
                chk_ptr_next = rd_ptr_reg[WADDR_W-1:0];
                if (rd_more) begin
                    rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                end
                if (scan_hit) begin
                    mem_we     = 1'b1;
                    frame_next = {chk_ptr_reg, ff_idx};
                    ok_next    = 1'b1;
                end
            end
            ST_XLAT: begin
                if (xst.done && xst.in_range) begin
                    mem_re        = 1'b1;
                    mem_raddr     = xframe[FRAME_W-1:IDX_W];
                    tgt_word_next = xframe[FRAME_W-1:IDX_W];
                    tgt_bit_next  = xframe[IDX_W-1:0];
                    ok_next       = 1'b1;
                end
            end
            ST_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = tgt_word_reg;
                mem_wdata = mem_rdata & ~(WORD_W'(1) << tgt_bit_reg);
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_page_address_next = prod[PA_W-1:0];
                    m_ok_next           = ok_reg;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_ptr_reg <= '0;
            chk_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_ptr_reg <= init_ptr_next;
            chk_vld_reg  <= chk_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= '0;
            virt_base_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PAGE_LIMIT: page_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                CFG_VIRT_BASE:  virt_base_reg  <= cfg_wdata;
                default:        page_limit_reg <= page_limit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg         <= rd_ptr_next;
        chk_ptr_reg        <= chk_ptr_next;
        last_word_reg      <= last_word_next;
        last_bit_reg       <= last_bit_next;
        tgt_word_reg       <= tgt_word_next;
        tgt_bit_reg        <= tgt_bit_next;
        frame_reg          <= frame_next;
        ok_reg             <= ok_next;
        m_page_address_reg <= m_page_address_next;
        m_ok_reg           <= m_ok_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_page_address = m_page_address_reg;
    assign m_ok           = m_ok_reg;

endmodule

`default_nettype wire

>>> src/pfa_map_mem.sv
// Used-map memory: one write port, one read port with registered data.
`default_nettype none

module pfa_map_mem #(
    parameter int NUM_WORDS = 64,
    parameter int WADDR_W   = 6
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [WADDR_W-1:0]        waddr,
    input  wire logic [pfa_pkg::WORD_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [WADDR_W-1:0]        raddr,
    output logic      [pfa_pkg::WORD_W-1:0] rdata
);
    import pfa_pkg::*;

    logic [WORD_W-1:0] mem [NUM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/pfa_find_free.sv
// First free bit of one used-map word under a window mask.
`default_nettype none

module pfa_find_free (
    input  wire logic [pfa_pkg::WORD_W-1:0] word,
    input  wire logic [pfa_pkg::WORD_W-1:0] mask,
    output logic                            any,
    output logic [pfa_pkg::IDX_W-1:0]       idx,
    output logic [pfa_pkg::WORD_W-1:0]      lowest
);
    import pfa_pkg::*;

    logic [WORD_W-1:0] free;

    assign free   = ~word & mask;
    // isolate the lowest set bit
    assign lowest = free & (~free + WORD_W'(1));
    assign any    = |free;

    // encode the one-hot position
    always_comb begin
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            for (int b = 0; b < IDX_W; b++) begin
                if (i[b]) begin
                    idx[b] = idx[b] | lowest[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> src/pfa_xlat.sv
// Free address translation: virtual base removal, range check, frame extraction.
`default_nettype none

module pfa_xlat #(
    parameter int MAX_PAGE_FRAMES = pfa_pkg::PFA_MAX_PAGE_FRAMES,
    parameter int PAGE_BYTES      = pfa_pkg::PFA_PAGE_BYTES,
    parameter int FRAME_W         = 12
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [pfa_pkg::DATA_W-1:0] address,
    input  wire logic [pfa_pkg::DATA_W-1:0] virt_base,
    output pfa_pkg::xlat_status_t           status,
    output logic      [FRAME_W-1:0]         frame
);
    import pfa_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [DATA_W-1:0] LIMIT_BYTES = DATA_W'(MAX_PAGE_FRAMES) * DATA_W'(PAGE_BYTES);

    xlat_phase_t        phase_reg, phase_next;
    logic [DATA_W-1:0]  phys_reg, phys_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               done_reg, done_next;
    logic               in_range_reg, in_range_next;
    logic               in_limit;

    assign in_limit = phys_reg < LIMIT_BYTES;

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            XP_IDLE: begin
                if (start) begin
                    phase_next = XP_RANGE;
                end
            end
            XP_RANGE: phase_next = XP_IDLE;
            default:  phase_next = XP_IDLE;
        endcase
    end

    always_comb begin
        phys_next     = phys_reg;
        frame_next    = frame_reg;
        done_next     = 1'b0;
        in_range_next = in_range_reg;
        unique case (phase_reg)
            XP_IDLE: begin
                if (start) begin
                    phys_next = (address > virt_base) ? address - virt_base : address;
                end
            end
            XP_RANGE: begin
                // page size is a power of two: the frame sits above the offset bits
                frame_next    = phys_reg[PAGE_SHIFT +: FRAME_W];
                in_range_next = in_limit;
                done_next     = 1'b1;
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= XP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        phys_reg     <= phys_next;
        frame_reg    <= frame_next;
        in_range_reg <= in_range_next;
    end

    assign status = '{done: done_reg, in_range: in_range_reg};
    assign frame  = frame_reg;

endmodule

`default_nettype wire

>>> src/pfa_checker.sv
// Port-level checks of the page frame allocator and their binding.
`default_nettype none

module pfa_checker (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [pfa_pkg::PA_W-1:0] m_page_address,
    input wire logic                     m_ok
);

    // a reset leaves no result pending
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // a failed allocation or a rejected free carries address zero
    a_fail_zero_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_page_address == '0))
        else $error("failed result with nonzero address");

    // one item in work at a time: no accept right after an accept
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_page_address) && $stable(m_ok)))
        else $error("stalled result changed");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);

`default_nettype wire
